### hdl/interrupt_pending_stack_defines.svh
// Assertion macros used by the checker file ips_checker.sv.
`ifndef INTERRUPT_PENDING_STACK_DEFINES_SVH
`define INTERRUPT_PENDING_STACK_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define IPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("interrupt_pending_stack: assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define IPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("interrupt_pending_stack: assertion failed");

`endif

### hdl/ips_pkg.sv
`default_nettype none
package ips_pkg;

    // Parameter defaults
    localparam int MAX_PENDING_DEF = 16;
    localparam int REASON_BITS_DEF = 8;

    // Fixed field widths
    localparam int OPCODE_W   = 3;
    localparam int REASON_W   = 8;
    localparam int COUNT_W    = 5;
    localparam int PERIOD_W   = 31;
    localparam int CD_W       = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);
    localparam logic [REASON_W-1:0] TREASON_RESET = REASON_W'(255);

    // Most negative countdown value
    localparam logic signed [CD_W-1:0] CD_MIN = {1'b1, {(CD_W-1){1'b0}}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_RAISE   = 3'd0,
        OP_TICK    = 3'd1,
        OP_POP     = 3'd2,
        OP_SERVICE = 3'd3,
        OP_ENABLE  = 3'd4,
        OP_DISABLE = 3'd5
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMER_PERIOD = 2'd0,
        CFG_TIMER_REASON = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP
    } t_state;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [REASON_W-1:0] reason;
    } t_item;

    typedef struct packed {
        logic [REASON_W-1:0] popped_reason;
        logic                popped_valid;
        logic                trap_request;
        logic                queued;
        logic [COUNT_W-1:0]  pending_count;
    } t_result;

endpackage
`default_nettype wire

### hdl/ips_store_ram.sv
`default_nettype none
module ips_store_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### hdl/interrupt_pending_stack.sv
`default_nettype none
// Pending interrupt stack: a last-in-first-out set of interrupt reasons without
// duplicates, with enable and handling flags and a tick countdown. An item is
// taken when start is high and busy is low. Its result shows on o_result for
// one cycle with o_strobe high. The result cannot be held off, so capture it
// in that cycle. Some items need no busy phase: busy stays low and the strobe
// follows in the next cycle. These are enable, disable, the unused opcodes,
// raises and ticks while interrupts are disabled, ticks that have not expired,
// pop or service of an empty stack, and raises or expiries into an empty or a
// full stack. Pop or service with an entry keeps busy high for one cycle (the
// registered read of the stack memory). A raise or timer expiry into a stack
// holding N entries (not full) scans the stack memory for a duplicate, one
// entry per cycle through its single read port. It stays busy until it finds
// a duplicate or has read all N entries; with no match it pushes the reason.
// Configuration writes are always taken (o_cfg_ready is high); write only
// while idle.
module interrupt_pending_stack #(
    parameter int MAX_PENDING = ips_pkg::MAX_PENDING_DEF,
    parameter int REASON_BITS = ips_pkg::REASON_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire ips_pkg::t_item           i_item,
    output logic                          o_strobe,
    output ips_pkg::t_result              o_result,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [ips_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ips_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import ips_pkg::*;

    localparam int IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam int CNT_W = $clog2(MAX_PENDING + 1);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_total, n_total;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic                     r_handling, n_handling;
    logic                     r_enabled, n_enabled;
    logic signed [CD_W-1:0]   r_countdown, n_countdown;
    logic [PERIOD_W-1:0]      r_period, n_period;
    logic [REASON_W-1:0]      r_treason, n_treason;
    logic [REASON_BITS-1:0]   r_hold, n_hold;
    logic                     r_strobe, n_strobe;
    t_result                  r_result, n_result;

    logic signed [CD_W-1:0]   dec_cd;
    logic                     expired;
    logic [REASON_W-1:0]      push_r;
    logic [REASON_BITS-1:0]   push_s;
    logic [CNT_W-1:0]         top_idx;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [REASON_BITS-1:0]   ram_wdata;
    logic [IDX_W-1:0]         ram_raddr;
    logic [REASON_BITS-1:0]   ram_rdata;

    ips_store_ram #(
        .DEPTH  (MAX_PENDING),
        .ADDR_W (IDX_W),
        .DATA_W (REASON_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

    // Next state, stack access and result
    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_idx       = r_idx;
        n_handling  = r_handling;
        n_enabled   = r_enabled;
        n_countdown = r_countdown;
        n_period    = r_period;
        n_treason   = r_treason;
        n_hold      = r_hold;
        n_strobe    = 1'b0;
        n_result    = r_result;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = r_hold;
        ram_raddr   = '0;

        // saturating countdown step
        dec_cd  = (r_countdown == CD_MIN) ? r_countdown : r_countdown - 1'b1;
        expired = dec_cd[CD_W-1] || (dec_cd == '0);
        push_r  = (i_item.opcode == OP_TICK) ? r_treason : i_item.reason;
        push_s  = REASON_BITS'(push_r);
        top_idx = r_total - 1'b1;

        // configuration writes
        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TIMER_PERIOD) begin
                n_period = i_cfg_data[PERIOD_W-1:0];
            end
            if (i_cfg_index == CFG_TIMER_REASON) begin
                n_treason = i_cfg_data[REASON_W-1:0];
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_result = '0;
                    unique case (i_item.opcode)
                        OP_RAISE, OP_TICK: begin
                            if (i_item.opcode == OP_TICK) begin
                                n_countdown = dec_cd;
                            end
                            if (!r_enabled || (i_item.opcode == OP_TICK && !expired)) begin
                                n_strobe = 1'b1;
                            end else if (r_total == '0) begin
                                // empty stack: no scan needed
                                ram_we                = 1'b1;
                                ram_waddr             = '0;
                                ram_wdata             = push_s;
                                n_total               = CNT_W'(1);
                                n_result.trap_request = !r_handling;
                                n_result.queued       = 1'b1;
                                n_strobe              = 1'b1;
                            end else if (r_total == CNT_W'(MAX_PENDING)) begin
                                // full: dropped
                                n_strobe = 1'b1;
                            end else begin
                                // start duplicate scan at entry 0
                                n_hold    = push_s;
                                ram_raddr = '0;
                                n_idx     = CNT_W'(1);
                                n_state   = ST_SCAN;
                            end
                        end
                        OP_POP, OP_SERVICE: begin
                            if (i_item.opcode == OP_SERVICE) begin
                                n_countdown = {1'b0, r_period};
                            end
                            if (r_total != '0) begin
                                ram_raddr = top_idx[IDX_W-1:0];
                                n_total   = top_idx;
                                if (i_item.opcode == OP_POP) begin
                                    n_handling = 1'b1;
                                end
                                n_state = ST_POP;
                            end else begin
                                if (i_item.opcode == OP_POP) begin
                                    n_handling = 1'b0;
                                end
                                n_strobe = 1'b1;
                            end
                        end
                        OP_ENABLE: begin
                            n_countdown = {1'b0, r_period};
                            n_enabled   = 1'b1;
                            n_strobe    = 1'b1;
                        end
                        OP_DISABLE: begin
                            n_enabled = 1'b0;
                            n_strobe  = 1'b1;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                    n_result.pending_count = COUNT_W'(n_total);
                end
            end
            ST_SCAN: begin
                // ram_rdata holds entry r_idx-1
                if (ram_rdata == r_hold) begin
                    n_result               = '0;
                    n_result.pending_count = COUNT_W'(r_total);
                    n_strobe               = 1'b1;
                    n_state                = ST_IDLE;
                end else if (r_idx == r_total) begin
                    ram_we                 = 1'b1;
                    ram_waddr              = r_total[IDX_W-1:0];
                    ram_wdata              = r_hold;
                    n_total                = r_total + 1'b1;
                    n_result               = '0;
                    n_result.queued        = 1'b1;
                    n_result.pending_count = COUNT_W'(n_total);
                    n_strobe               = 1'b1;
                    n_state                = ST_IDLE;
                end else begin
                    ram_raddr = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + 1'b1;
                end
            end
            ST_POP: begin
                n_result               = '0;
                n_result.popped_reason = REASON_W'(ram_rdata);
                n_result.popped_valid  = 1'b1;
                n_result.pending_count = COUNT_W'(r_total);
                n_strobe               = 1'b1;
                n_state                = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_idx       <= '0;
            r_handling  <= 1'b0;
            r_enabled   <= 1'b0;
            r_countdown <= '0;
            r_period    <= PERIOD_RESET;
            r_treason   <= TREASON_RESET;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_idx       <= n_idx;
            r_handling  <= n_handling;
            r_enabled   <= n_enabled;
            r_countdown <= n_countdown;
            r_period    <= n_period;
            r_treason   <= n_treason;
            r_strobe    <= n_strobe;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_hold   <= n_hold;
        r_result <= n_result;
    end

endmodule
`default_nettype wire

### hdl/ips_checker.sv
`default_nettype none
`include "interrupt_pending_stack_defines.svh"
module ips_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_start,
    input wire logic             i_busy,
    input wire ips_pkg::t_item   i_item,
    input wire logic             i_strobe,
    input wire ips_pkg::t_result i_result
);

    import ips_pkg::*;

    // every accepted item either strobes next cycle or holds the block busy
    `IPS_ASSERT_NEXT(a_accept_progress, i_start && !i_busy, i_strobe || i_busy)

    // a result never shows while an item is still at work
    `IPS_ASSERT_IMP(a_no_strobe_busy, i_busy, !i_strobe)

    // leaving busy always delivers the result
    `IPS_ASSERT_IMP(a_busy_end_strobe, $fell(i_busy) && $past(i_rst_n), i_strobe)

    // a pop result never also reports a push
    `IPS_ASSERT_IMP(a_pop_excl_push, i_strobe && i_result.popped_valid, !i_result.queued && !i_result.trap_request)

    // enable and disable answer next cycle with no pop and no push
    `IPS_ASSERT_NEXT(a_mode_result, i_start && !i_busy && (i_item.opcode == OP_ENABLE || i_item.opcode == OP_DISABLE), i_strobe && !i_result.popped_valid && !i_result.queued)

endmodule

bind interrupt_pending_stack ips_checker u_ips_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (start),
    .i_busy   (busy),
    .i_item   (i_item),
    .i_strobe (o_strobe),
    .i_result (o_result)
);
`default_nettype wire
